// ===== hw/rtl/xcfr_pkg.sv =====
// Shared types and constants of the XOR-checked frame receiver.
`default_nettype none

package xcfr_pkg;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned EV_W   = 3;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned CLS_W  = 2;
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 10;

  // Largest length that fits the frame_length field
  localparam logic [LEN_W-1:0] LEN_SAT = '1;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_HDR1    = 2'd0;
  localparam logic [CFG_AW-1:0] REG_HDR2    = 2'd1;
  localparam logic [CFG_AW-1:0] REG_VERSION = 2'd2;
  localparam logic [CFG_AW-1:0] REG_LIMIT   = 2'd3;

  // Register reset values
  localparam logic [BYTE_W-1:0] HDR1_RST    = 8'h55;
  localparam logic [BYTE_W-1:0] HDR2_RST    = 8'hAA;
  localparam logic [BYTE_W-1:0] VERSION_RST = 8'h01;
  localparam logic [LEN_W-1:0]  LIMIT_RST   = 10'd512;

  // Command codes with a class of their own
  localparam logic [BYTE_W-1:0] CMD_ACK   = 8'h81;
  localparam logic [BYTE_W-1:0] CMD_CLOUD = 8'h82;

  typedef enum logic [2:0] {
    PH_HDR1,
    PH_HDR2,
    PH_VER,
    PH_CMD,
    PH_LENL,
    PH_LENH,
    PH_PAY,
    PH_CHK
  } phase_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE    = 3'd0,
    EV_DATA    = 3'd1,
    EV_OK      = 3'd2,
    EV_BADSUM  = 3'd3,
    EV_BADVER  = 3'd4,
    EV_TOOLONG = 3'd5
  } ev_t;

  typedef enum logic [CLS_W-1:0] {
    CLS_OTHER = 2'd0,
    CLS_ACK   = 2'd1,
    CLS_CLOUD = 2'd2
  } cmd_class_t;

  // Register file contents
  typedef struct packed {
    logic [BYTE_W-1:0] hdr1;
    logic [BYTE_W-1:0] hdr2;
    logic [BYTE_W-1:0] version;
    logic [LEN_W-1:0]  limit;
  } cfg_t;

  // One result word
  typedef struct packed {
    ev_t               event_res;
    logic [BYTE_W-1:0] data_byte;
    logic [POS_W-1:0]  byte_position;
    logic [BYTE_W-1:0] frame_command;
    logic [LEN_W-1:0]  frame_length;
    cmd_class_t        command_class;
  } result_t;

  function automatic cmd_class_t class_of(input logic [BYTE_W-1:0] cmd);
    cmd_class_t cls;
    if (cmd == CMD_ACK) begin
      cls = CLS_ACK;
    end else if (cmd == CMD_CLOUD) begin
      cls = CLS_CLOUD;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/xcfr_rx_if.sv =====
// Receive byte channel.
`default_nettype none

interface xcfr_rx_if;
  import xcfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/xcfr_res_if.sv =====
// Result channel.
`default_nettype none

interface xcfr_res_if;
  import xcfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [EV_W-1:0]   event_res;
  logic [BYTE_W-1:0] data_byte;
  logic [POS_W-1:0]  byte_position;
  logic [BYTE_W-1:0] frame_command;
  logic [LEN_W-1:0]  frame_length;
  logic [CLS_W-1:0]  command_class;

  modport source (
    output valid, output event_res, output data_byte, output byte_position,
    output frame_command, output frame_length, output command_class,
    input ready
  );
  modport sink (
    input valid, input event_res, input data_byte, input byte_position,
    input frame_command, input frame_length, input command_class,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/xcfr_cfg_if.sv =====
// Configuration write channel.
`default_nettype none

interface xcfr_cfg_if;
  import xcfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/xcfr_cfg_regs.sv =====
// Configuration register file.
`default_nettype none

module xcfr_cfg_regs
  import xcfr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  xcfr_cfg_if.sink   cfg,
  output cfg_t       regs
);

  // Writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.hdr1    <= HDR1_RST;
      regs.hdr2    <= HDR2_RST;
      regs.version <= VERSION_RST;
      regs.limit   <= LIMIT_RST;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_HDR1:    regs.hdr1    <= cfg.data[BYTE_W-1:0];
        REG_HDR2:    regs.hdr2    <= cfg.data[BYTE_W-1:0];
        REG_VERSION: regs.version <= cfg.data[BYTE_W-1:0];
        REG_LIMIT:   regs.limit   <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/xcfr_parser.sv =====
// Frame parse state and the per-byte decode of one received byte.
`default_nettype none

module xcfr_parser
  import xcfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [BYTE_W-1:0] byte_in,
  input  wire cfg_t              regs,
  output result_t                res
);

  // Payload bound set by the field widths and the build limit
  localparam int unsigned LIM_CAP = (MAX_PAYLOAD < 1023) ? MAX_PAYLOAD : 1023;
  localparam int unsigned CNT_W   = $clog2(LIM_CAP + 1);
  localparam logic [LEN_W-1:0] LIM_CAP_V = LEN_W'(LIM_CAP);

  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] command, command_next;
  logic [BYTE_W-1:0] csum, csum_next;
  logic [BYTE_W-1:0] len_lo, len_lo_next;
  logic [LEN_W-1:0]  length, length_next;
  logic [CNT_W-1:0]  count, count_next;

  logic [LEN_W-1:0]    eff_limit;
  logic [2*BYTE_W-1:0] len_full;
  logic [LEN_W:0]      count_inc;
  logic [CNT_W+POS_W-1:0] pos_ext;
  ev_t                 ev;
  logic                framed;

  assign eff_limit = (regs.limit > LIM_CAP_V) ? LIM_CAP_V : regs.limit;
  assign len_full  = {byte_in, len_lo};
  assign count_inc = (LEN_W + 1)'(count) + 1'b1;
  assign pos_ext   = {{POS_W{1'b0}}, count};

  // Next state and event
  always_comb begin
    phase_next   = phase;
    command_next = command;
    csum_next    = csum;
    len_lo_next  = len_lo;
    length_next  = length;
    count_next   = count;
    ev           = EV_NONE;
    case (phase)
      PH_HDR1: begin
        if (byte_in == regs.hdr1) begin
          phase_next = PH_HDR2;
        end
      end
      PH_HDR2: begin
        phase_next = (byte_in == regs.hdr2) ? PH_VER : PH_HDR1;
      end
      PH_VER: begin
        if (byte_in == regs.version) begin
          csum_next  = byte_in;
          phase_next = PH_CMD;
        end else begin
          ev         = EV_BADVER;
          phase_next = PH_HDR1;
        end
      end
      PH_CMD: begin
        command_next = byte_in;
        csum_next    = csum ^ byte_in;
        phase_next   = PH_LENL;
      end
      PH_LENL: begin
        len_lo_next = byte_in;
        csum_next   = csum ^ byte_in;
        phase_next  = PH_LENH;
      end
      PH_LENH: begin
        csum_next   = csum ^ byte_in;
        count_next  = '0;
        // saturate for the report; in range it is exact
        length_next = (len_full > (2*BYTE_W)'(LEN_SAT)) ? LEN_SAT : len_full[LEN_W-1:0];
        if (len_full > (2*BYTE_W)'(eff_limit)) begin
          ev         = EV_TOOLONG;
          phase_next = PH_HDR1;
        end else if (len_full == '0) begin
          phase_next = PH_CHK;
        end else begin
          phase_next = PH_PAY;
        end
      end
      PH_PAY: begin
        csum_next  = csum ^ byte_in;
        count_next = count_inc[CNT_W-1:0];
        ev         = EV_DATA;
        if (count_inc >= {1'b0, length}) begin
          phase_next = PH_CHK;
        end
      end
      PH_CHK: begin
        ev         = (byte_in == csum) ? EV_OK : EV_BADSUM;
        phase_next = PH_HDR1;
      end
      default: begin
        phase_next = PH_HDR1;
      end
    endcase
  end

  // Result word
  always_comb begin
    framed = (ev == EV_DATA) || (ev == EV_OK) || (ev == EV_BADSUM) || (ev == EV_TOOLONG);
    res.event_res     = ev;
    res.data_byte     = (ev == EV_DATA) ? byte_in : '0;
    res.byte_position = (ev == EV_DATA) ? pos_ext[POS_W-1:0] : '0;
    res.frame_command = framed ? command_next : '0;
    res.frame_length  = framed ? length_next : '0;
    res.command_class = framed ? class_of(command_next) : CLS_OTHER;
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HDR1;
      command <= '0;
      csum    <= '0;
      len_lo  <= '0;
      length  <= '0;
      count   <= '0;
    end else if (step) begin
      phase   <= phase_next;
      command <= command_next;
      csum    <= csum_next;
      len_lo  <= len_lo_next;
      length  <= length_next;
      count   <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/xor_checked_frame_receiver_unit.sv =====
// Data path: an accepted byte goes into the input register and moves on into the
// result register once that register is free or its word is being taken.
// Throughput: one byte per cycle while the result channel is not stalled; the
// parse state update is logic between the input register and the result register.
// Reset (rst, synchronous, active high) empties both registers, returns the
// parser to waiting for the first header byte and loads the register defaults.
// Configuration writes are taken in every cycle.
`default_nettype none

module xor_checked_frame_receiver_unit
  import xcfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  wire logic  clk,
  input  wire logic  rst,
  xcfr_rx_if.sink    rx,
  xcfr_res_if.source res,
  xcfr_cfg_if.sink   cfg
);

  cfg_t              regs;
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              out_valid;
  result_t           out_word;
  result_t           word_next;
  logic              advance;

  xcfr_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  xcfr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .byte_in (in_byte),
    .regs    (regs),
    .res     (word_next)
  );

  // Handshake: the held byte moves on when the result register frees up
  assign advance  = in_valid && (!out_valid || res.ready);
  assign rx.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= word_next;
    end
  end

  assign res.valid         = out_valid;
  assign res.event_res     = out_word.event_res;
  assign res.data_byte     = out_word.data_byte;
  assign res.byte_position = out_word.byte_position;
  assign res.frame_command = out_word.frame_command;
  assign res.frame_length  = out_word.frame_length;
  assign res.command_class = out_word.command_class;

endmodule

`default_nettype wire
